// File: src/tafn_pkg.sv
// ----------------------------------------------------------------------------
// tafn_pkg
// Shared widths, datapath commands and controller/datapath status for the
// triangle assembly and face normal block.
// ----------------------------------------------------------------------------
package tafn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;
    localparam int DIFF_WIDTH       = COORD_WIDTH + 1;
    localparam int PROD_WIDTH       = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH      = PROD_WIDTH + 1;
    localparam int FIT_BIT          = 30;
    localparam int SUM_WIDTH        = 2 * FIT_BIT + 2;
    localparam int ROOT_WIDTH       = SUM_WIDTH / 2;
    localparam int ROOT_STEPS       = SUM_WIDTH / 2;
    localparam int QUOT_WIDTH       = FIT_BIT + NORMAL_FRAC_BITS + 1;
    localparam int STEP_WIDTH       = $clog2(QUOT_WIDTH + 1);
    localparam int MUL_STEPS        = 6;
    localparam int VERTEX_BITS      = 3 * COORD_WIDTH;
    localparam int IN_DATA_WIDTH    = ((VERTEX_BITS + 7) / 8) * 8;
    localparam int OUT_BITS         = 9 * COORD_WIDTH + 3 * NORMAL_WIDTH;
    localparam int OUT_DATA_WIDTH   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_MUL,
        OP_ABS,
        OP_FIT,
        OP_SQR,
        OP_ROOT_INIT,
        OP_ROOT,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_SAVE,
        OP_ZERO
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic c_zero;
        logic fit_ok;
    } t_sts;

endpackage

// File: src/tafn_ctrl.sv
// ----------------------------------------------------------------------------
// tafn_ctrl
// Sequencer: counts vertices into triangles and steps the datapath through
// differences, cross product, scaling, square root, three divisions or zero normal.
// ----------------------------------------------------------------------------
module tafn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_out_free,
    input  tafn_pkg::t_sts  i_sts,
    output tafn_pkg::t_cmd  o_cmd,
    output logic            o_ready,
    output logic            o_done
);
    import tafn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_ABS,
        S_CHECK,
        S_FIT,
        S_SQR,
        S_RINIT,
        S_ROOT,
        S_DINIT,
        S_DIV,
        S_DSAVE,
        S_ZERO,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_count;
    logic [STEP_WIDTH-1:0] r_step;
    logic [1:0]            r_idx;

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_out_free;

    always_comb begin
        o_cmd.op  = OP_NONE;
        o_cmd.idx = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.op  = OP_LOAD;
                    o_cmd.idx = {1'b0, r_count};
                end
            end
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_MUL: begin
                o_cmd.op  = OP_MUL;
                o_cmd.idx = r_step[2:0];
            end
            S_ABS:   o_cmd.op = OP_ABS;
            S_FIT:   o_cmd.op = OP_FIT;
            S_SQR: begin
                o_cmd.op  = OP_SQR;
                o_cmd.idx = {1'b0, r_idx};
            end
            S_RINIT: o_cmd.op = OP_ROOT_INIT;
            S_ROOT:  o_cmd.op = OP_ROOT;
            S_DINIT: begin
                o_cmd.op  = OP_DIV_INIT;
                o_cmd.idx = {1'b0, r_idx};
            end
            S_DIV:   o_cmd.op = OP_DIV;
            S_DSAVE: begin
                o_cmd.op  = OP_DIV_SAVE;
                o_cmd.idx = {1'b0, r_idx};
            end
            S_ZERO:  o_cmd.op = OP_ZERO;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        if (r_count == 2'd2) begin
                            r_count <= '0;
                            r_state <= S_DIFF;
                        end else begin
                            r_count <= r_count + 2'd1;
                        end
                    end
                end
                S_DIFF: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + STEP_WIDTH'(1);
                    if (r_step == STEP_WIDTH'(MUL_STEPS - 1)) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS:   r_state <= S_CHECK;
                S_CHECK: r_state <= i_sts.c_zero ? S_ZERO : S_FIT;
                S_FIT: begin
                    if (i_sts.fit_ok) begin
                        r_idx   <= '0;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd2) begin
                        r_state <= S_RINIT;
                    end
                end
                S_RINIT: begin
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_step <= r_step + STEP_WIDTH'(1);
                    if (r_step == STEP_WIDTH'(ROOT_STEPS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + STEP_WIDTH'(1);
                    if (r_step == STEP_WIDTH'(QUOT_WIDTH - 1)) begin
                        r_state <= S_DSAVE;
                    end
                end
                S_DSAVE: begin
                    r_idx   <= r_idx + 2'd1;
                    r_state <= (r_idx == 2'd2) ? S_DONE : S_DINIT;
                end
                S_ZERO: r_state <= S_DONE;
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_load_only_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |-> (r_state == S_IDLE);
    endproperty
    a_load_only_idle: assert property (p_load_only_idle)
        else $error("vertex load outside idle");

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3;
    endproperty
    a_count_range: assert property (p_count_range)
        else $error("vertex count out of range");

    property p_done_leaves;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE);
    endproperty
    a_done_leaves: assert property (p_done_leaves)
        else $error("controller stuck after done");

endmodule

// File: src/tafn_dp.sv
// ----------------------------------------------------------------------------
// tafn_dp
// Datapath: held vertices, edge differences, shared multiplier for the cross
// product, squarer, scaling shifter, bitwise square root and a
// restoring divider that produces the three normal components.
// ----------------------------------------------------------------------------
module tafn_dp (
    input  logic                                   i_clk,
    input  tafn_pkg::t_cmd                         i_cmd,
    input  logic signed [tafn_pkg::COORD_WIDTH-1:0]  i_vx,
    input  logic signed [tafn_pkg::COORD_WIDTH-1:0]  i_vy,
    input  logic signed [tafn_pkg::COORD_WIDTH-1:0]  i_vz,
    output tafn_pkg::t_sts                         o_sts,
    output logic signed [tafn_pkg::COORD_WIDTH-1:0]  o_p0 [3],
    output logic signed [tafn_pkg::COORD_WIDTH-1:0]  o_p1 [3],
    output logic signed [tafn_pkg::COORD_WIDTH-1:0]  o_p2 [3],
    output logic signed [tafn_pkg::NORMAL_WIDTH-1:0] o_n  [3]
);
    import tafn_pkg::*;

    logic signed [COORD_WIDTH-1:0]  r_p0 [3];
    logic signed [COORD_WIDTH-1:0]  r_p1 [3];
    logic signed [COORD_WIDTH-1:0]  r_p2 [3];
    logic signed [DIFF_WIDTH-1:0]   r_a  [3];
    logic signed [DIFF_WIDTH-1:0]   r_b  [3];
    logic signed [CROSS_WIDTH-1:0]  r_c  [3];
    logic        [CROSS_WIDTH-1:0]  r_cm [3];
    logic                           r_cs [3];
    logic        [SUM_WIDTH-1:0]    r_s;
    logic        [SUM_WIDTH-1:0]    r_rn;
    logic        [SUM_WIDTH-1:0]    r_rr;
    logic        [SUM_WIDTH-1:0]    r_rbit;
    logic        [ROOT_WIDTH-1:0]   r_rem;
    logic        [QUOT_WIDTH-1:0]   r_quo;
    logic signed [NORMAL_WIDTH-1:0] r_n  [3];

    logic signed [DIFF_WIDTH-1:0]   w_ma;
    logic signed [DIFF_WIDTH-1:0]   w_mb;
    logic signed [PROD_WIDTH-1:0]   w_prod;
    logic signed [CROSS_WIDTH-1:0]  w_prod_ext;
    logic        [CROSS_WIDTH-1:0]  w_max01;
    logic        [CROSS_WIDTH-1:0]  w_max;
    logic                           w_big;
    logic                           w_small;
    logic        [FIT_BIT-1:0]      w_sq_in;
    logic        [2*FIT_BIT-1:0]    w_sq;
    logic        [SUM_WIDTH-1:0]    w_trial;
    logic        [ROOT_WIDTH-1:0]   w_len;
    logic        [ROOT_WIDTH:0]     w_shift;
    logic                           w_ge;
    logic        [NORMAL_WIDTH-1:0] w_q;

    always_comb begin
        w_ma = r_a[0];
        w_mb = r_b[0];
        case (i_cmd.idx)
            3'd0: begin w_ma = r_a[1]; w_mb = r_b[2]; end
            3'd1: begin w_ma = r_a[2]; w_mb = r_b[1]; end
            3'd2: begin w_ma = r_a[2]; w_mb = r_b[0]; end
            3'd3: begin w_ma = r_a[0]; w_mb = r_b[2]; end
            3'd4: begin w_ma = r_a[0]; w_mb = r_b[1]; end
            3'd5: begin w_ma = r_a[1]; w_mb = r_b[0]; end
            default: begin w_ma = r_a[0]; w_mb = r_b[0]; end
        endcase
    end

    assign w_prod     = w_ma * w_mb;
    assign w_prod_ext = {w_prod[PROD_WIDTH-1], w_prod};

    assign w_max01 = (r_cm[0] > r_cm[1]) ? r_cm[0] : r_cm[1];
    assign w_max   = (w_max01 > r_cm[2]) ? w_max01 : r_cm[2];
    assign w_big   = (w_max >> FIT_BIT) != '0;
    assign w_small = (w_max >> (FIT_BIT - 1)) == '0;

    assign o_sts.c_zero = (w_max == '0);
    assign o_sts.fit_ok = !w_big && !w_small;

    assign w_sq_in = r_cm[i_cmd.idx[1:0]][FIT_BIT-1:0];
    assign w_sq    = w_sq_in * w_sq_in;
    assign w_trial = r_rr + r_rbit;
    assign w_len   = r_rr[ROOT_WIDTH-1:0];
    assign w_shift = {r_rem, r_quo[QUOT_WIDTH-1]};
    assign w_ge    = w_shift >= {1'b0, w_len};
    assign w_q     = {1'b0, r_quo[NORMAL_FRAC_BITS:0]};

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                case (i_cmd.idx)
                    3'd0: begin r_p0[0] <= i_vx; r_p0[1] <= i_vy; r_p0[2] <= i_vz; end
                    3'd1: begin r_p1[0] <= i_vx; r_p1[1] <= i_vy; r_p1[2] <= i_vz; end
                    default: begin
                        r_p2[0] <= i_vx; r_p2[1] <= i_vy; r_p2[2] <= i_vz;
                    end
                endcase
            end
            OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i] <= DIFF_WIDTH'(r_p0[i]) - DIFF_WIDTH'(r_p1[i]);
                    r_b[i] <= DIFF_WIDTH'(r_p0[i]) - DIFF_WIDTH'(r_p2[i]);
                end
            end
            OP_MUL: begin
                if (i_cmd.idx[0]) begin
                    r_c[i_cmd.idx[2:1]] <= r_c[i_cmd.idx[2:1]] - w_prod_ext;
                end else begin
                    r_c[i_cmd.idx[2:1]] <= w_prod_ext;
                end
            end
            OP_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    r_cs[i] <= r_c[i][CROSS_WIDTH-1];
                    r_cm[i] <= r_c[i][CROSS_WIDTH-1] ? CROSS_WIDTH'(-r_c[i])
                                                     : CROSS_WIDTH'(r_c[i]);
                end
            end
            OP_FIT: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_big) begin
                        r_cm[i] <= r_cm[i] >> 1;
                    end else if (w_small) begin
                        r_cm[i] <= r_cm[i] << 1;
                    end
                end
            end
            OP_SQR: begin
                if (i_cmd.idx == 3'd0) begin
                    r_s <= SUM_WIDTH'(w_sq);
                end else begin
                    r_s <= r_s + SUM_WIDTH'(w_sq);
                end
            end
            OP_ROOT_INIT: begin
                r_rn   <= r_s;
                r_rr   <= '0;
                r_rbit <= SUM_WIDTH'(1) << (SUM_WIDTH - 2);
            end
            OP_ROOT: begin
                if (r_rn >= w_trial) begin
                    r_rn <= r_rn - w_trial;
                    r_rr <= (r_rr >> 1) + r_rbit;
                end else begin
                    r_rr <= r_rr >> 1;
                end
                r_rbit <= r_rbit >> 2;
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_quo <= QUOT_WIDTH'({w_sq_in, {NORMAL_FRAC_BITS{1'b0}}})
                       + QUOT_WIDTH'(w_len >> 1);
            end
            OP_DIV: begin
                r_rem <= w_ge ? ROOT_WIDTH'(w_shift - {1'b0, w_len})
                              : ROOT_WIDTH'(w_shift);
                r_quo <= {r_quo[QUOT_WIDTH-2:0], w_ge};
            end
            OP_DIV_SAVE: begin
                r_n[i_cmd.idx[1:0]] <= r_cs[i_cmd.idx[1:0]] ? -w_q : w_q;
            end
            OP_ZERO: begin
                for (int i = 0; i < 3; i++) begin
                    r_n[i] <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;
    assign o_p2 = r_p2;
    assign o_n  = r_n;

endmodule

// File: src/triangle_assembly_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_assembly_face_normal
// Groups vertices three at a time and emits each triangle with its unit face
// normal in Q2.14 (zero for a degenerate triangle).
//
//   channel   dir  tdata fields (low bit first)
//   s_axis    in   vertex_x, vertex_y, vertex_z             (48 bits)
//   m_axis    out  first_xyz, second_xyz, third_xyz,
//                  normal_x, normal_y, normal_z             (192 bits)
//
// The first two vertices of a triangle are accepted back to back. After the
// third is accepted the block computes the differences, a 6-step shared
// multiplier pass, magnitude and zero check, scaling (one bit per cycle, up
// to 29 shifts), three squares, a 31-step square root plus setup and three
// 45-step divisions with setup and save, then presents the result.
// A degenerate triangle goes straight to a zero normal after the zero check.
// Reset is synchronous, active low; no memory clearing pass is needed.
// A stalled output holds its transaction while the next vertices are taken.
// ----------------------------------------------------------------------------
module triangle_assembly_face_normal (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // vertex_x, vertex_y, vertex_z
    input  logic [tafn_pkg::IN_DATA_WIDTH-1:0]    i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z, normal_x, normal_y, normal_z
    output logic [tafn_pkg::OUT_DATA_WIDTH-1:0]   o_m_axis_tdata
);
    import tafn_pkg::*;

    t_cmd                          w_cmd;
    t_sts                          w_sts;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_done;
    logic signed [COORD_WIDTH-1:0]  w_p0 [3];
    logic signed [COORD_WIDTH-1:0]  w_p1 [3];
    logic signed [COORD_WIDTH-1:0]  w_p2 [3];
    logic signed [NORMAL_WIDTH-1:0] w_n  [3];

    logic                          r_out_valid;
    logic [OUT_DATA_WIDTH-1:0]     r_out_data;
    logic [OUT_DATA_WIDTH-1:0]     n_out_data;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    tafn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_ready    (o_s_axis_tready),
        .o_done     (w_done)
    );

    tafn_dp u_dp (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .i_vx  (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_vy  (i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_vz  (i_s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .o_sts (w_sts),
        .o_p0  (w_p0),
        .o_p1  (w_p1),
        .o_p2  (w_p2),
        .o_n   (w_n)
    );

    assign n_out_data = OUT_DATA_WIDTH'({w_n[2], w_n[1], w_n[0],
                                         w_p2[2], w_p2[1], w_p2[0],
                                         w_p1[2], w_p1[1], w_p1[0],
                                         w_p0[2], w_p0[1], w_p0[0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!r_out_valid || i_m_axis_tready);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("pending transaction overwritten");

    property p_done_shows;
        @(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_m_axis_tvalid;
    endproperty
    a_done_shows: assert property (p_done_shows)
        else $error("finished triangle not presented");

    property p_normal_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_n[0] <= (NORMAL_WIDTH'(1) <<< NORMAL_FRAC_BITS)
                 && w_n[0] >= -(NORMAL_WIDTH'(1) <<< NORMAL_FRAC_BITS));
    endproperty
    a_normal_range: assert property (p_normal_range)
        else $error("normal component beyond unit length");

endmodule
